// ===== rtl/core/jqd_pkg.sv =====
// shared constants and types for the joystick quantize and debounce block
// no dependencies

package jqd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int HOLD_BITS   = 8;

  localparam int LIMIT_BITS    = 10;
  localparam int NUM_LIMITS    = 10;
  localparam int LIMITS_LO_NUM = 6;
  localparam int LIMITS_HI_NUM = NUM_LIMITS - LIMITS_LO_NUM;
  localparam int CFG_HOLD_BITS = 8;
  localparam int LEVEL_BITS    = 7;
  localparam int DIR_BITS      = 2;
  localparam int LEVEL_STEP    = 10;
  localparam int LEVEL_FULL    = 100;

  localparam int IN_FIELDS_W  = 4 * SAMPLE_BITS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * LEVEL_BITS + 2 * DIR_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = LIMITS_LO_NUM * LIMIT_BITS;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [IN_DATA_W-1:0]   in_data_t;
  typedef logic [OUT_DATA_W-1:0]  out_data_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [HOLD_BITS-1:0]   hold_t;
  typedef logic [LEVEL_BITS-1:0]  level_t;
  typedef logic [DIR_BITS-1:0]    dir_t;

  localparam cfg_index_t REG_STICK_MODE     = 3'd0;
  localparam cfg_index_t REG_LIMITS_LOW     = 3'd1;
  localparam cfg_index_t REG_LIMITS_HIGH    = 3'd2;
  localparam cfg_index_t REG_BACK_LIMIT     = 3'd3;
  localparam cfg_index_t REG_FORE_LIMIT     = 3'd4;
  localparam cfg_index_t REG_THROTTLE_HOLD  = 3'd5;
  localparam cfg_index_t REG_STEER_HOLD     = 3'd6;

  localparam dir_t DIR_OFF  = 2'd0;
  localparam dir_t DIR_FORE = 2'd1;
  localparam dir_t DIR_BACK = 2'd2;

  localparam logic STICK_RIGHT = 1'b0;
  localparam logic STICK_LEFT  = 1'b1;

endpackage

// ===== rtl/core/joystick_quantize_debounce.sv =====
// joystick quantize and debounce top level: input register, per-tick
// quantize/classify and four debounce channels; depends on jqd_pkg

// One item (one tick of four stick samples) is taken per cycle while
// out_tready stays high. An item is registered at the input, then quantized,
// classified and debounced as it advances from the input register into the
// result register, which drives out_tdata; throughput is one item per cycle
// while out_tready stays high. The input register and the result
// register let one item wait on each side while the output is stalled.
// Configuration writes are always accepted; cfg_ready is tied high.
module joystick_quantize_debounce (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // left_vertical, left_horizontal, right_vertical, right_horizontal
  input  jqd_pkg::in_data_t     in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // level_vertical, level_horizontal, dir_vertical, dir_horizontal
  output jqd_pkg::out_data_t    out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  jqd_pkg::cfg_index_t   cfg_index,
  input  jqd_pkg::cfg_data_t    cfg_data
);

  import jqd_pkg::*;

  localparam int CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;
  localparam int HW       = (HOLD_BITS > CFG_HOLD_BITS) ? HOLD_BITS : CFG_HOLD_BITS;
  localparam hold_t HOLD_MAX = '1;

  // configuration
  logic                                   stick_mode_r;
  logic [LIMITS_LO_NUM*LIMIT_BITS-1:0]    limits_lo_r;
  logic [LIMITS_HI_NUM*LIMIT_BITS-1:0]    limits_hi_r;
  logic [LIMIT_BITS-1:0]                  back_limit_r;
  logic [LIMIT_BITS-1:0]                  fore_limit_r;
  logic [CFG_HOLD_BITS-1:0]               thr_hold_r;
  logic [CFG_HOLD_BITS-1:0]               str_hold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_mode_r <= STICK_LEFT;
      limits_lo_r  <= '0;
      limits_hi_r  <= '0;
      back_limit_r <= '0;
      fore_limit_r <= '1;
      thr_hold_r   <= '0;
      str_hold_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STICK_MODE:    stick_mode_r <= cfg_data[0];
        REG_LIMITS_LOW:    limits_lo_r  <= cfg_data[LIMITS_LO_NUM*LIMIT_BITS-1:0];
        REG_LIMITS_HIGH:   limits_hi_r  <= cfg_data[LIMITS_HI_NUM*LIMIT_BITS-1:0];
        REG_BACK_LIMIT:    back_limit_r <= cfg_data[LIMIT_BITS-1:0];
        REG_FORE_LIMIT:    fore_limit_r <= cfg_data[LIMIT_BITS-1:0];
        REG_THROTTLE_HOLD: thr_hold_r   <= cfg_data[CFG_HOLD_BITS-1:0];
        REG_STEER_HOLD:    str_hold_r   <= cfg_data[CFG_HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                   s1_valid_r;
  logic [IN_FIELDS_W-1:0] s1_data_r;
  logic                   out_valid_r;
  logic                   s1_adv;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata[IN_FIELDS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // stick selection
  sample_t lv, lh, rv, rh;
  sample_t tv, th, cv, ch;

  assign lv = s1_data_r[0*SAMPLE_BITS +: SAMPLE_BITS];
  assign lh = s1_data_r[1*SAMPLE_BITS +: SAMPLE_BITS];
  assign rv = s1_data_r[2*SAMPLE_BITS +: SAMPLE_BITS];
  assign rh = s1_data_r[3*SAMPLE_BITS +: SAMPLE_BITS];

  always_comb begin
    if (stick_mode_r == STICK_LEFT) begin
      tv = lv; th = lh; cv = rv; ch = rh;
    end else begin
      tv = rv; th = rh; cv = lv; ch = lh;
    end
  end

  // quantize and classify
  logic [LIMIT_BITS-1:0] limits [NUM_LIMITS];

  always_comb begin
    for (int i = 0; i < LIMITS_LO_NUM; i++) begin
      limits[i] = limits_lo_r[i*LIMIT_BITS +: LIMIT_BITS];
    end
    for (int i = 0; i < LIMITS_HI_NUM; i++) begin
      limits[LIMITS_LO_NUM+i] = limits_hi_r[i*LIMIT_BITS +: LIMIT_BITS];
    end
  end

  function automatic level_t quantize(sample_t s,
                                      logic [LIMIT_BITS-1:0] lim [NUM_LIMITS]);
    level_t lvl;
    lvl = LEVEL_BITS'(LEVEL_FULL);
    for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
      if (CMP_BITS'(s) < CMP_BITS'(lim[i])) begin
        lvl = LEVEL_BITS'(LEVEL_STEP * (i + 1));
      end
    end
    return lvl;
  endfunction

  function automatic dir_t classify(sample_t s, logic [LIMIT_BITS-1:0] bl,
                                    logic [LIMIT_BITS-1:0] fl);
    dir_t d;
    priority if (CMP_BITS'(s) < CMP_BITS'(bl)) begin
      d = DIR_BACK;
    end else if (CMP_BITS'(s) > CMP_BITS'(fl)) begin
      d = DIR_FORE;
    end else begin
      d = DIR_OFF;
    end
    return d;
  endfunction

  function automatic hold_t eff_hold(logic [CFG_HOLD_BITS-1:0] h);
    logic [HW-1:0] hw;
    hw = HW'(h);
    if (hw > HW'(HOLD_MAX)) begin
      return HOLD_MAX;
    end
    return HOLD_BITS'(hw);
  endfunction

  level_t raw_lvl [2];
  dir_t   raw_dir [2];

  assign raw_lvl[0] = quantize(tv, limits);
  assign raw_lvl[1] = quantize(th, limits);
  assign raw_dir[0] = classify(cv, back_limit_r, fore_limit_r);
  assign raw_dir[1] = classify(ch, back_limit_r, fore_limit_r);

  // debounce channels: throttle v, throttle h, steer v, steer h
  level_t lvl_pend_r [2];
  level_t lvl_stab_r [2];
  dir_t   dir_pend_r [2];
  dir_t   dir_stab_r [2];
  hold_t  cnt_r      [4];

  level_t lvl_pend_nxt [2];
  level_t lvl_stab_nxt [2];
  dir_t   dir_pend_nxt [2];
  dir_t   dir_stab_nxt [2];
  hold_t  cnt_nxt      [4];

  hold_t  thr_eff, str_eff;
  logic   chg   [4];
  hold_t  cbase [4];
  hold_t  heff  [4];

  assign thr_eff = eff_hold(thr_hold_r);
  assign str_eff = eff_hold(str_hold_r);

  always_comb begin
    chg[0]  = lvl_pend_r[0] != raw_lvl[0];
    chg[1]  = lvl_pend_r[1] != raw_lvl[1];
    chg[2]  = dir_pend_r[0] != raw_dir[0];
    chg[3]  = dir_pend_r[1] != raw_dir[1];
    heff[0] = thr_eff;
    heff[1] = thr_eff;
    heff[2] = str_eff;
    heff[3] = str_eff;
    for (int c = 0; c < 4; c++) begin
      cbase[c] = chg[c] ? '0 : cnt_r[c];
      cnt_nxt[c] = (cbase[c] >= heff[c]) ? cbase[c] : cbase[c] + 1'b1;
    end
    for (int k = 0; k < 2; k++) begin
      lvl_pend_nxt[k] = raw_lvl[k];
      dir_pend_nxt[k] = raw_dir[k];
      lvl_stab_nxt[k] = (cbase[k] >= heff[k]) ? raw_lvl[k] : lvl_stab_r[k];
      dir_stab_nxt[k] = (cbase[k+2] >= heff[k+2]) ? raw_dir[k] : dir_stab_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 2; k++) begin
        lvl_pend_r[k] <= '0;
        lvl_stab_r[k] <= '0;
        dir_pend_r[k] <= DIR_OFF;
        dir_stab_r[k] <= DIR_OFF;
      end
      for (int c = 0; c < 4; c++) begin
        cnt_r[c] <= '0;
      end
    end else if (s1_adv) begin
      lvl_pend_r <= lvl_pend_nxt;
      lvl_stab_r <= lvl_stab_nxt;
      dir_pend_r <= dir_pend_nxt;
      dir_stab_r <= dir_stab_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // the stable registers are the result register
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({dir_stab_r[1], dir_stab_r[0],
                                   lvl_stab_r[1], lvl_stab_r[0]});

  // assertions
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r))
    else $error("input blocked without two items held");

  a_item_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("held item lost from input register");

  a_result_stable_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(lvl_stab_r[0]) && $stable(dir_stab_r[1]))
    else $error("debounce state changed while result stalled");

  a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lvl_stab_r[0] <= LEVEL_BITS'(LEVEL_FULL)) && (lvl_stab_r[1] <= LEVEL_BITS'(LEVEL_FULL))
    && (dir_stab_r[0] != 2'd3) && (dir_stab_r[1] != 2'd3))
    else $error("published value out of range");

endmodule
